/* design/wwts_pkg.sv */
// Package for the whole-word text search block: request and result types,
// configuration register codes, character constants and small helpers.
// No dependencies.
package wwts_pkg;

    localparam int COUNTER_BITS            = 24;
    localparam int MAX_QUERY_BYTES_DEFAULT = 16;
    localparam int QUERY_REG_BYTES         = 8;
    localparam int CFG_INDEX_BITS          = 3;
    localparam int CFG_DATA_BITS           = 64;
    localparam int QUEUE_DEPTH             = 4;
    localparam int QUEUE_PTR_BITS          = $clog2(QUEUE_DEPTH);

    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;
    localparam logic [15:0] DEFAULT_MATCH_LIMIT = 16'd1000;

    localparam logic [7:0] CHAR_LF         = 8'h0A;
    localparam logic [7:0] CHAR_CR         = 8'h0D;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_QUERY_LOW   = 3'd0,
        REG_QUERY_HIGH  = 3'd1,
        REG_QUERY_LEN   = 3'd2,
        REG_MATCH_CASE  = 3'd3,
        REG_WHOLE_WORD  = 3'd4,
        REG_MATCH_LIMIT = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_of_file;
        logic [15:0] file_tag;
    } in_item_t;

    typedef struct packed {
        logic [15:0]             match_file;
        logic [COUNTER_BITS-1:0] match_line;
        logic [COUNTER_BITS-1:0] column;
        logic                    limit_reached;
        logic                    last_in_run;
    } out_item_t;

    typedef struct packed {
        logic [63:0] query_low;
        logic [63:0] query_high;
        logic [4:0]  query_length;
        logic        match_case;
        logic        whole_word;
        logic [15:0] match_limit;
    } cfg_t;

    function automatic logic is_word(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], CHAR_UNDERSCORE};
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c inside {[8'h41:8'h5A]})
            return c + 8'd32;
        return c;
    endfunction

    // bytes past the second query register read as zero
    function automatic logic [7:0] query_byte(input logic [63:0] lo, input logic [63:0] hi,
                                              input int i);
        if (i < QUERY_REG_BYTES)
            return lo[8*i +: 8];
        if (i < 2*QUERY_REG_BYTES)
            return hi[8*(i-QUERY_REG_BYTES) +: 8];
        return 8'h00;
    endfunction

    function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] v);
        if (v == CNT_MAX)
            return v;
        return v + 1'b1;
    endfunction

endpackage

/* design/wwts_cfg.sv */
// Configuration registers of the text search, with the clamped query length
// and the whole-word enable derived from them.
// Depends on wwts_pkg.
module wwts_cfg
    import wwts_pkg::*;
#(
    parameter int MAX_QUERY_BYTES = MAX_QUERY_BYTES_DEFAULT,
    localparam int LEN_W = $clog2(MAX_QUERY_BYTES + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                      cfg,
    output logic [LEN_W-1:0]          len,
    output logic                      ww_active
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.query_low    <= '0;
            cfg_reg.query_high   <= '0;
            cfg_reg.query_length <= 5'd1;
            cfg_reg.match_case   <= 1'b1;
            cfg_reg.whole_word   <= 1'b0;
            cfg_reg.match_limit  <= DEFAULT_MATCH_LIMIT;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_QUERY_LOW:   cfg_reg.query_low    <= cfg_data;
                REG_QUERY_HIGH:  cfg_reg.query_high   <= cfg_data;
                REG_QUERY_LEN:   cfg_reg.query_length <= cfg_data[4:0];
                REG_MATCH_CASE:  cfg_reg.match_case   <= cfg_data[0];
                REG_WHOLE_WORD:  cfg_reg.whole_word   <= cfg_data[0];
                REG_MATCH_LIMIT: cfg_reg.match_limit  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

    always_comb
    begin
        if (cfg_reg.query_length == 5'd0)
            len = LEN_W'(1);
        else if (int'(cfg_reg.query_length) > MAX_QUERY_BYTES)
            len = LEN_W'(MAX_QUERY_BYTES);
        else
            len = LEN_W'(cfg_reg.query_length);
    end

    // whole-word mode only counts when every query byte in use is a word character
    always_comb
    begin
        ww_active = cfg_reg.whole_word;
        for (int i = 0; i < MAX_QUERY_BYTES; i++)
        begin
            if (i < int'(len) &&
                !is_word(query_byte(cfg_reg.query_low, cfg_reg.query_high, i)))
                ww_active = 1'b0;
        end
    end

endmodule

/* design/wwts_window_cmp.sv */
// Parallel compare of the query against the recent-byte window, plus the
// word test on the byte just before a candidate match.
// Depends on wwts_pkg.
module wwts_window_cmp
    import wwts_pkg::*;
#(
    parameter int MAX_QUERY_BYTES = MAX_QUERY_BYTES_DEFAULT,
    localparam int LEN_W = $clog2(MAX_QUERY_BYTES + 1)
)
(
    input  logic [7:0]       window [0:MAX_QUERY_BYTES],
    input  logic [63:0]      query_low,
    input  logic [63:0]      query_high,
    input  logic             match_case,
    input  logic [LEN_W-1:0] len,
    output logic             bytes_match,
    output logic             before_is_word
);

    logic [LEN_W-1:0] idx [MAX_QUERY_BYTES];
    logic [7:0]       w_byte [MAX_QUERY_BYTES];
    logic [7:0]       q_byte [MAX_QUERY_BYTES];

    // window is newest first, so query byte i sits at len-1-i
    always_comb
    begin
        bytes_match = 1'b1;
        for (int i = 0; i < MAX_QUERY_BYTES; i++)
        begin
            idx[i]    = len - LEN_W'(1) - LEN_W'(i);
            w_byte[i] = window[idx[i]];
            q_byte[i] = query_byte(query_low, query_high, i);
            if (!match_case)
            begin
                w_byte[i] = fold_case(w_byte[i]);
                q_byte[i] = fold_case(q_byte[i]);
            end
            if (i < int'(len) && w_byte[i] != q_byte[i])
                bytes_match = 1'b0;
        end
    end

    assign before_is_word = is_word(window[len]);

endmodule

/* design/wwts_result_queue.sv */
// 4-entry result queue: up to two in per cycle, one out unless out_stall.
// Depends on wwts_pkg.
module wwts_result_queue
    import wwts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic [1:0] push_count,
    input  out_item_t push0,
    input  out_item_t push1,
    output logic      room,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    out_item_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_BITS:0]   count_reg, count_next;
    logic                      pop;
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_plus1;

    assign out_valid    = (count_reg != '0);
    assign out_data     = entry_reg[rd_ptr_reg];
    assign pop          = out_valid && !out_stall;
    assign room         = (count_reg <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_BITS'(push_count);
        rd_ptr_next = rd_ptr_reg + QUEUE_PTR_BITS'(pop);
        count_next  = count_reg + (QUEUE_PTR_BITS+1)'(push_count)
                                - (QUEUE_PTR_BITS+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            entry_reg[wr_ptr_reg] <= push0;
        if (push_count == 2'd2)
            entry_reg[wr_ptr_plus1] <= push1;
    end

endmodule

/* design/whole_word_text_search.sv */
// Whole-word text search: top level with input register, line/column state,
// match resolution and match limit. Depends on wwts_pkg, wwts_cfg,
// wwts_window_cmp and wwts_result_queue.

// One file byte is taken per clock cycle while in_stall is low. Each request
// lands in an input register; from there the query is compared against the
// recent-byte window in one pass, state is updated and any results go into a
// four-entry result queue. A byte produces at most two results (a whole-word
// match resolved by this byte, then a new match) and the output side moves one
// result per cycle while out_stall is low, so the rate stays at one byte per
// cycle as long as bytes average no more than one result. in_stall rises when
// a request is held and the queue has fewer than two free entries. The user
// must write configuration only while the block is idle; nothing enforces it.
module whole_word_text_search
    import wwts_pkg::*;
#(
    parameter int MAX_QUERY_BYTES = MAX_QUERY_BYTES_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  in_item_t                  in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output out_item_t                 out_data
);

    localparam int LEN_W = $clog2(MAX_QUERY_BYTES + 1);

    cfg_t             cfg;
    logic [LEN_W-1:0] len;
    logic             ww_active;

    logic     s1_valid_reg, s1_valid_next;
    in_item_t s1_reg;
    logic     room;
    logic     adv;

    logic [7:0]              win_reg [0:MAX_QUERY_BYTES];
    logic [7:0]              win_next [0:MAX_QUERY_BYTES];
    logic [7:0]              win_sh [0:MAX_QUERY_BYTES];
    logic [COUNTER_BITS-1:0] column_reg, column_next;
    logic [COUNTER_BITS-1:0] line_reg, line_next;
    logic [COUNTER_BITS-1:0] next_start_reg, next_start_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [COUNTER_BITS-1:0] pend_line_reg, pend_line_next;
    logic [COUNTER_BITS-1:0] pend_col_reg, pend_col_next;
    logic                    pend_before_ok_reg, pend_before_ok_next;
    logic [15:0]             match_count_reg, match_count_next;
    logic                    limit_hit_reg, limit_hit_next;

    logic                    bytes_match, before_is_word;
    logic [7:0]              b;
    logic                    eol, last;
    logic [COUNTER_BITS-1:0] col_inc, len_ext, start, ln;
    logic                    hit, before_ok;
    logic                    e1, e2, ok1, ok2, lr1, lr2, hit1, hit2;
    logic [15:0]             cnt1, cnt2;
    out_item_t               res_pend, res_new, push0, push1;
    logic [1:0]              push_count;

    wwts_cfg #(.MAX_QUERY_BYTES(MAX_QUERY_BYTES)) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .len       (len),
        .ww_active (ww_active)
    );

    // input register
    assign in_stall = s1_valid_reg && !room;
    assign adv      = s1_valid_reg && room;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_valid && !in_stall)
            s1_valid_next = 1'b1;
        else if (adv)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_reg <= in_data;
    end

    assign b    = s1_reg.data_byte;
    assign last = s1_reg.last_of_file;
    assign eol  = (b == CHAR_LF) || (b == CHAR_CR);

    always_comb
    begin
        win_sh[0] = b;
        for (int k = 1; k <= MAX_QUERY_BYTES; k++)
            win_sh[k] = win_reg[k-1];
    end

    wwts_window_cmp #(.MAX_QUERY_BYTES(MAX_QUERY_BYTES)) u_cmp (
        .window         (win_sh),
        .query_low      (cfg.query_low),
        .query_high     (cfg.query_high),
        .match_case     (cfg.match_case),
        .len            (len),
        .bytes_match    (bytes_match),
        .before_is_word (before_is_word)
    );

    // match detection
    always_comb
    begin
        col_inc   = sat_inc(column_reg);
        len_ext   = COUNTER_BITS'(len);
        start     = col_inc - len_ext;
        hit       = !eol && (col_inc >= len_ext) && (start >= next_start_reg) && bytes_match;
        before_ok = (start == '0) || !before_is_word;
        ln        = sat_inc(line_reg);
        e1        = pend_valid_reg && pend_before_ok_reg && (eol || !is_word(b));
        e2        = hit && (!ww_active || (last && before_ok));
    end

    // emit chain: the waiting match goes first, then the new one
    always_comb
    begin
        ok1  = e1 && !limit_hit_reg && (match_count_reg < cfg.match_limit);
        cnt1 = ok1 ? match_count_reg + 16'd1 : match_count_reg;
        lr1  = ok1 && (cnt1 >= cfg.match_limit);
        hit1 = limit_hit_reg || (e1 && !ok1) || lr1;
        ok2  = e2 && !hit1 && (cnt1 < cfg.match_limit);
        cnt2 = ok2 ? cnt1 + 16'd1 : cnt1;
        lr2  = ok2 && (cnt2 >= cfg.match_limit);
        hit2 = hit1 || (e2 && !ok2) || lr2;

        res_pend.match_file    = s1_reg.file_tag;
        res_pend.match_line    = pend_line_reg;
        res_pend.column        = pend_col_reg;
        res_pend.limit_reached = lr1;
        res_pend.last_in_run   = !ok2;

        res_new.match_file     = s1_reg.file_tag;
        res_new.match_line     = ln;
        res_new.column         = start + 1'b1;
        res_new.limit_reached  = lr2;
        res_new.last_in_run    = 1'b1;

        push0      = ok1 ? res_pend : res_new;
        push1      = res_new;
        push_count = adv ? (2'(ok1) + 2'(ok2)) : 2'd0;
    end

    // state update
    always_comb
    begin
        win_next            = win_reg;
        column_next         = column_reg;
        line_next           = line_reg;
        next_start_next     = next_start_reg;
        pend_valid_next     = pend_valid_reg;
        pend_line_next      = pend_line_reg;
        pend_col_next       = pend_col_reg;
        pend_before_ok_next = pend_before_ok_reg;
        match_count_next    = match_count_reg;
        limit_hit_next      = limit_hit_reg;

        if (adv)
        begin
            match_count_next = cnt2;
            limit_hit_next   = hit2;
            pend_valid_next  = hit && ww_active && !last;
            if (hit)
            begin
                pend_line_next      = ln;
                pend_col_next       = start + 1'b1;
                pend_before_ok_next = before_ok;
            end

            if (eol)
            begin
                line_next       = ln;
                column_next     = '0;
                next_start_next = '0;
            end
            else
            begin
                win_next    = win_sh;
                column_next = col_inc;
                if (hit)
                    next_start_next = col_inc;
            end

            if (last)
            begin
                for (int k = 0; k <= MAX_QUERY_BYTES; k++)
                    win_next[k] = 8'h00;
                column_next     = '0;
                next_start_next = '0;
                line_next       = '0;
                pend_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= MAX_QUERY_BYTES; k++)
                win_reg[k] <= 8'h00;
            column_reg         <= '0;
            line_reg           <= '0;
            next_start_reg     <= '0;
            pend_valid_reg     <= 1'b0;
            pend_line_reg      <= '0;
            pend_col_reg       <= '0;
            pend_before_ok_reg <= 1'b0;
            match_count_reg    <= '0;
            limit_hit_reg      <= 1'b0;
        end
        else
        begin
            win_reg            <= win_next;
            column_reg         <= column_next;
            line_reg           <= line_next;
            next_start_reg     <= next_start_next;
            pend_valid_reg     <= pend_valid_next;
            pend_line_reg      <= pend_line_next;
            pend_col_reg       <= pend_col_next;
            pend_before_ok_reg <= pend_before_ok_next;
            match_count_reg    <= match_count_next;
            limit_hit_reg      <= limit_hit_next;
        end
    end

    wwts_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (push0),
        .push1      (push1),
        .room       (room),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    // once the limit is reached it stays reached until reset
    a_limit_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        limit_hit_reg |=> limit_hit_reg)
        else $error("limit flag dropped");

    // a result flagged at the limit can only leave after the limit was recorded
    a_limit_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.limit_reached) |-> limit_hit_reg)
        else $error("limit_reached result without limit recorded");

    // the overlap barrier never runs ahead of the column counter
    a_overlap_barrier: assert property (@(posedge clk) disable iff (!rst_n)
        next_start_reg <= column_reg)
        else $error("next allowed start beyond column");

    // no request is lost: a held request stays held while stalled
    a_hold_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !room) |=> s1_valid_reg)
        else $error("input register dropped a request");

endmodule

/* tb/whole_word_text_search_tb.sv */
// Testbench for whole_word_text_search: bursty byte requests against a stalling
// result port, checked against an in-bench prediction of the search.
// Depends on wwts_pkg and whole_word_text_search.
module whole_word_text_search_tb;
    import wwts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_LONG
    } stall_mode_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    in_item_t                  in_data;
    logic                      out_valid;
    logic                      out_stall;
    out_item_t                 out_data;

    // register copies used by the prediction
    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [4:0]  pat_len;
    logic        exact_case;
    logic        whole_word_req;
    logic [15:0] report_cap;

    // search state
    logic [7:0]              win_bytes [0:MAX_QUERY_BYTES_DEFAULT];
    logic [COUNTER_BITS-1:0] col_pos;
    logic [COUNTER_BITS-1:0] line_pos;
    logic [COUNTER_BITS-1:0] resume_col;
    logic                    held_valid;
    logic [COUNTER_BITS-1:0] held_line;
    logic [COUNTER_BITS-1:0] held_col;
    logic                    held_before_ok;
    logic [15:0]             reported;
    logic                    limit_done;

    in_item_t  bytes_to_send [$];
    out_item_t step_matches [$];
    out_item_t expected_matches [$];
    int        mismatches;
    logic [15:0] file_id;

    int          burst_left;
    int          gap_left;
    stall_mode_t stall_mode;
    int          stall_mode_left;
    int          stall_run;

    whole_word_text_search i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    function automatic logic word_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == CHAR_UNDERSCORE;
    endfunction

    function automatic logic [7:0] lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic [COUNTER_BITS-1:0] bump(input logic [COUNTER_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic int pattern_len();
        if (pat_len == 0)
            return 1;
        if (pat_len > MAX_QUERY_BYTES_DEFAULT)
            return MAX_QUERY_BYTES_DEFAULT;
        return int'(pat_len);
    endfunction

    function automatic logic [7:0] pattern_byte(input int i);
        if (i < 8)
            return pat_lo[8*i +: 8];
        if (i < 16)
            return pat_hi[8*(i-8) +: 8];
        return 8'h00;
    endfunction

    function automatic logic whole_word_on();
        logic on;
        on = whole_word_req;
        for (int i = 0; i < pattern_len(); i++)
            if (!word_char(pattern_byte(i)))
                on = 1'b0;
        return on;
    endfunction

    function automatic void clear_search();
        foreach (win_bytes[k])
            win_bytes[k] = 8'h00;
        col_pos        = '0;
        line_pos       = '0;
        resume_col     = '0;
        held_valid     = 1'b0;
        held_line      = '0;
        held_col       = '0;
        held_before_ok = 1'b0;
    endfunction

    function automatic void record_match(input logic [15:0] tag,
                                         input logic [COUNTER_BITS-1:0] ln,
                                         input logic [COUNTER_BITS-1:0] col);
        out_item_t m;
        if (limit_done || reported >= report_cap)
        begin
            limit_done = 1'b1;
            return;
        end
        reported        = reported + 1'b1;
        m.match_file    = tag;
        m.match_line    = ln;
        m.column        = col;
        m.limit_reached = 1'b0;
        m.last_in_run   = 1'b0;
        if (reported >= report_cap)
        begin
            limit_done      = 1'b1;
            m.limit_reached = 1'b1;
        end
        step_matches.insert(step_matches.size(), m);
    endfunction

    // advance the search by one accepted byte and queue the matches it reports
    function automatic void search_byte(input in_item_t item);
        logic [7:0]              b;
        logic                    eol;
        logic                    ww;
        int                      len;
        logic [COUNTER_BITS-1:0] start;
        logic [COUNTER_BITS-1:0] ln;
        logic                    hit;
        logic                    before_ok;
        logic [7:0]              w;
        logic [7:0]              q;
        b   = item.data_byte;
        eol = (b == CHAR_LF) || (b == CHAR_CR);
        ww  = whole_word_on();
        len = pattern_len();
        step_matches.delete();

        if (held_valid)
        begin
            held_valid = 1'b0;
            if (held_before_ok && (eol || !word_char(b)))
                record_match(item.file_tag, held_line, held_col);
        end

        if (eol)
        begin
            line_pos   = bump(line_pos);
            col_pos    = '0;
            resume_col = '0;
        end
        else
        begin
            for (int k = MAX_QUERY_BYTES_DEFAULT; k > 0; k--)
                win_bytes[k] = win_bytes[k-1];
            win_bytes[0] = b;
            col_pos = bump(col_pos);
            if (col_pos >= COUNTER_BITS'(len))
            begin
                start = col_pos - COUNTER_BITS'(len);
                hit   = (start >= resume_col);
                for (int i = 0; i < len; i++)
                begin
                    w = win_bytes[len-1-i];
                    q = pattern_byte(i);
                    if (!exact_case)
                    begin
                        w = lower(w);
                        q = lower(q);
                    end
                    if (w != q)
                        hit = 1'b0;
                end
                if (hit)
                begin
                    before_ok  = (start == '0) || !word_char(win_bytes[len]);
                    ln         = bump(line_pos);
                    resume_col = col_pos;
                    if (!ww)
                        record_match(item.file_tag, ln, start + 1'b1);
                    else if (item.last_of_file)
                    begin
                        if (before_ok)
                            record_match(item.file_tag, ln, start + 1'b1);
                    end
                    else
                    begin
                        held_valid     = 1'b1;
                        held_line      = ln;
                        held_col       = start + 1'b1;
                        held_before_ok = before_ok;
                    end
                end
            end
        end

        if (item.last_of_file)
            clear_search();

        if (step_matches.size() > 0)
            step_matches[step_matches.size()-1].last_in_run = 1'b1;
        foreach (step_matches[k])
            expected_matches.insert(expected_matches.size(), step_matches[k]);
    endfunction

    function automatic logic [7:0] rand_word_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26)
            return 8'(8'h61 + r);
        if (r < 52)
            return 8'(8'h41 + (r - 26));
        if (r < 62)
            return 8'(8'h30 + (r - 52));
        return CHAR_UNDERSCORE;
    endfunction

    function automatic logic [7:0] vary_case(input logic [7:0] c);
        if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) &&
            $urandom_range(0, exact_case ? 7 : 1) == 0)
            return c ^ 8'h20;
        return c;
    endfunction

    function automatic void push_byte(input logic [7:0] b, input logic last,
                                      input logic [15:0] tag);
        in_item_t it;
        it.data_byte    = b;
        it.last_of_file = last;
        it.file_tag     = tag;
        bytes_to_send.insert(bytes_to_send.size(), it);
    endfunction

    function automatic void push_text(input string s, input logic [15:0] tag);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], 1'b0, tag);
    endfunction

    // mostly copies of the query with word and separator noise around them
    function automatic void queue_random_text(input int count);
        logic [7:0] chunk [$];
        int         pick;
        int         k;
        int         n;
        logic       last;
        n = 0;
        while (n < count)
        begin
            chunk.delete();
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                for (int i = 0; i < pattern_len(); i++)
                    chunk.insert(chunk.size(), vary_case(pattern_byte(i)));
            end
            else if (pick < 52)
            begin
                k = $urandom_range(1, pattern_len());
                for (int i = 0; i < k; i++)
                    chunk.insert(chunk.size(), vary_case(pattern_byte(i)));
            end
            else if (pick < 72)
            begin
                repeat ($urandom_range(1, 4))
                    chunk.insert(chunk.size(), rand_word_char());
            end
            else if (pick < 86)
            begin
                case ($urandom_range(0, 4))
                    0:       chunk.insert(chunk.size(), " ");
                    1:       chunk.insert(chunk.size(), ",");
                    2:       chunk.insert(chunk.size(), ".");
                    3:       chunk.insert(chunk.size(), "-");
                    default: chunk.insert(chunk.size(), 8'(8'h80 + $urandom_range(0, 127)));
                endcase
            end
            else if (pick < 93)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        chunk.insert(chunk.size(), CHAR_CR);
                        chunk.insert(chunk.size(), CHAR_LF);
                    end
                    1:       chunk.insert(chunk.size(), CHAR_CR);
                    default: chunk.insert(chunk.size(), CHAR_LF);
                endcase
            end
            else
                chunk.insert(chunk.size(), 8'($urandom_range(0, 255)));
            last = ($urandom_range(0, 11) == 0);
            foreach (chunk[i])
                push_byte(chunk[i], last && (i == chunk.size() - 1), file_id);
            n += chunk.size();
            if (last)
                file_id = 16'($urandom);
        end
    endfunction

    task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // narrow registers get random upper bits, which the block must ignore
    task automatic set_search(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] len, input logic cs, input logic wwd,
                              input logic [15:0] lim);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(REG_QUERY_LOW, lo);
        write_reg(REG_QUERY_HIGH, hi);
        write_reg(REG_QUERY_LEN, {junk[63:5], len});
        write_reg(REG_MATCH_CASE, {junk[63:1], cs});
        write_reg(REG_WHOLE_WORD, {junk[62:0], wwd});
        write_reg(REG_MATCH_LIMIT, {junk[47:0], lim});
        pat_lo         = lo;
        pat_hi         = hi;
        pat_len        = len;
        exact_case     = cs;
        whole_word_req = wwd;
        report_cap     = lim;
        @(negedge clk);
    endtask

    // the block may still be busy on a request that reports nothing
    task automatic wait_idle();
        do
            @(negedge clk);
        while (bytes_to_send.size() != 0 || in_valid || expected_matches.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #1ms;
        $display("whole_word_text_search_tb failed");
        $finish;
    end

    // request driver: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                search_byte(in_data);
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (bytes_to_send.size() > 0)
                begin
                    in_data  <= bytes_to_send.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 40);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result stall pattern: stretches of no stall, random, periodic and long stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall       <= 1'b0;
            stall_mode      = STALL_NONE;
            stall_mode_left = 0;
            stall_run       = 0;
        end
        else
        begin
            if (stall_mode_left == 0)
            begin
                stall_mode      = stall_mode_t'($urandom_range(0, 3));
                stall_mode_left = $urandom_range(20, 200);
            end
            stall_mode_left--;
            case (stall_mode)
                STALL_NONE:     out_stall <= 1'b0;
                STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
                STALL_PERIODIC: out_stall <= ((stall_mode_left % 5) < 3);
                default:
                begin
                    if (stall_run == 0 && $urandom_range(0, 15) == 0)
                        stall_run = $urandom_range(4, 12);
                    if (stall_run > 0)
                    begin
                        stall_run--;
                        out_stall <= 1'b1;
                    end
                    else
                        out_stall <= 1'b0;
                end
            endcase
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_matches.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected match: file %h line %0d col %0d limit %b last %b",
                             out_data.match_file, out_data.match_line, out_data.column,
                             out_data.limit_reached, out_data.last_in_run);
            end
            else
            begin
                want = expected_matches.pop_front();
                if (out_data.match_file !== want.match_file ||
                    out_data.match_line !== want.match_line ||
                    out_data.column !== want.column ||
                    out_data.limit_reached !== want.limit_reached ||
                    out_data.last_in_run !== want.last_in_run)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"match mismatch: expected file %h line %0d col %0d limit %b ",
                                  "last %b, got file %h line %0d col %0d limit %b last %b"},
                                 want.match_file, want.match_line, want.column,
                                 want.limit_reached, want.last_in_run,
                                 out_data.match_file, out_data.match_line, out_data.column,
                                 out_data.limit_reached, out_data.last_in_run);
                end
            end
        end
    end

    initial
    begin
        logic [127:0] q;
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        mismatches = 0;
        file_id    = 16'($urandom);
        pat_lo         = '0;
        pat_hi         = '0;
        pat_len        = 5'd1;
        exact_case     = 1'b1;
        whole_word_req = 1'b0;
        report_cap     = DEFAULT_MATCH_LIMIT;
        reported       = '0;
        limit_done     = 1'b0;
        clear_search();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // registers at their reset values: a single NUL byte query
        push_byte(8'h00, 1'b0, 16'h0000);
        push_byte(8'hFF, 1'b0, 16'h0000);
        push_byte(8'h00, 1'b1, 16'hFFFF);
        wait_idle();

        // whole word with case folding: kept, rejected by the byte after,
        // resolved at end of line, and one left waiting at the end
        set_search(64'h0000_0000_395F_6241, 64'h0, 5'd4, 1'b0, 1'b1, 16'hFFFF);
        push_text("ab_9 AB_9x,aB_9\r\nab_9", 16'h1234);
        wait_idle();
        // waiting match resolved under a non-word query: two results for one request
        set_search(64'h0000_0000_0000_002C, 64'h0, 5'd1, 1'b1, 1'b0, 16'hFFFF);
        push_byte(",", 1'b0, 16'hEDCB);
        push_byte(8'h80, 1'b1, 16'hEDCB);
        wait_idle();

        // short word query, folded, whole word
        q = '0;
        for (int i = 0; i < 16; i++)
            q[8*i +: 8] = rand_word_char();
        set_search(q[63:0], q[127:64], 5'($urandom_range(1, 3)), 1'b0, 1'b1, 16'hFFFF);
        queue_random_text(170);
        wait_idle();

        // longest word query, exact
        for (int i = 0; i < 16; i++)
            q[8*i +: 8] = rand_word_char();
        set_search(q[63:0], q[127:64], 5'd16, 1'b1, 1'b1, 16'hFFFF);
        queue_random_text(160);
        wait_idle();

        // arbitrary query bytes, length zero taken as one
        q = {$urandom, $urandom, $urandom, $urandom};
        set_search(q[63:0], q[127:64], 5'd0, 1'b1, 1'b1, 16'hFFFF);
        queue_random_text(150);
        wait_idle();

        // arbitrary query bytes, oversize length clipped to sixteen
        q = {$urandom, $urandom, $urandom, $urandom};
        set_search(q[63:0], q[127:64], 5'($urandom_range(17, 31)), 1'b0, 1'b0, 16'hFFFF);
        queue_random_text(150);
        wait_idle();

        // query holding line ends never matches
        for (int i = 0; i < 16; i++)
            q[8*i +: 8] = rand_word_char();
        q[15:8]  = CHAR_LF;
        q[23:16] = CHAR_CR;
        set_search(q[63:0], q[127:64], 5'd31 - 5'd28, 1'b0, 1'($urandom_range(0, 1)), 16'hFFFF);
        queue_random_text(60);
        wait_idle();

        // limit a little above the running count, so it can be reached in this phase
        for (int i = 0; i < 16; i++)
            q[8*i +: 8] = rand_word_char();
        set_search(q[63:0], q[127:64], 5'($urandom_range(2, 5)), 1'b0,
                   1'($urandom_range(0, 1)), reported + 16'($urandom_range(5, 20)));
        queue_random_text(200);
        wait_idle();

        // limit at one and at zero once it has been passed
        set_search(q[63:0], q[127:64], 5'd1, 1'b0, 1'b0, 16'd1);
        queue_random_text(40);
        wait_idle();
        set_search(q[63:0], q[127:64], 5'd1, 1'b1, 1'b0, 16'd0);
        queue_random_text(20);
        wait_idle();

        if (mismatches == 0)
            $display("whole_word_text_search_tb passed");
        else
            $display("whole_word_text_search_tb failed");
        $finish;
    end

endmodule
